### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg : shared types and constants of the point-in-polygon core
// Coordinate widths, action codes, queue sizing and the word that the front
// end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Coordinate width; differences carry one more bit, products twice that.
  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;

  // Exterior rings with fewer vertices than this never report inside.
  localparam int MIN_EXTERIOR = 3;
  localparam int CNT_W        = $clog2(MIN_EXTERIOR + 1);

  // Stream widths.
  localparam int IN_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;

  // Queue between front and back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Action codes carried in the input tuser.
  localparam logic [1:0] ACT_QUERY    = 2'd0;
  localparam logic [1:0] ACT_EXTERIOR = 2'd1;
  localparam logic [1:0] ACT_HOLE     = 2'd2;

  typedef enum logic {
    OP_CLEAR,
    OP_VERTEX
  } op_t;

  // One edge test, reduced to the four differences of the cross-multiplied
  // comparison plus the side test and the sign of dy.
  typedef struct packed {
    logic                     hit;
    logic                     dy_neg;
    logic signed [DIFF_W-1:0] ax;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] by;
  } edge_t;

  typedef struct packed {
    op_t   op;
    logic  hole;
    logic  close;
    logic  emit;
    logic  enough;
    edge_t e0;
    edge_t e1;
  } entry_t;

endpackage

### rtl/point_in_polygon_with_holes_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_with_holes_core : streamed even-odd point-in-polygon test
// A query word sets the point; vertex words of the exterior ring and then the
// hole rings follow, and the word marked as polygon end yields one result.
//
//   channel  direction  tdata (low bit first)          tuser / tlast
//   in_      slave      coord_x, coord_y               action, ring_last / polygon_last
//   out_     master     inside_res, too_few_vertices   none
//
// Cycles: one word is accepted per clock cycle when the output is taken;
// a result appears on out_tvalid once the polygon-end word has passed the
// queue, the product register and the result register.
// Reset: rst_n is synchronous and active low; the query point and all ring
// state return to zero, as if a query at the origin had been given.
// Stalls: a two-word queue parts the front from the back end, and the result
// register lets the back end keep working until a second result is due.
// ----------------------------------------------------------------------------
module point_in_polygon_with_holes_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pip_pkg::IN_TDATA_W-1:0]  in_tdata,  // coord_x, coord_y
  input  logic [pip_pkg::IN_TUSER_W-1:0]  in_tuser,  // action[1:0], ring_last
  input  logic                            in_tlast,  // polygon_last
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pip_pkg::OUT_TDATA_W-1:0] out_tdata  // inside_res, too_few_vertices, zeros
);

  logic            accept;
  logic            push;
  logic            q_full, q_not_empty, q_pop;
  pip_pkg::entry_t push_entry, q_entry;

  // The front end holds nothing between words, so the queue's space alone
  // decides whether a word can be taken.
  assign in_tready = !q_full;
  assign accept    = in_tvalid & in_tready;

  pip_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .tdata (in_tdata),
    .tuser (in_tuser),
    .tlast (in_tlast),
    .push  (push),
    .entry (push_entry)
  );

  pip_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_entry),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (q_entry)
  );

  // The back end forms the products of both edge tests in one stage and
  // resolves parity and the result in the next.
  pip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_data     (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front : input word classification and edge set-up
// Holds the query point and ring bookkeeping, and turns each accepted vertex
// into its edge tests (the edge to the previous vertex and, at a ring
// end, the closing edge) for the back end.
// ----------------------------------------------------------------------------
module pip_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [pip_pkg::IN_TDATA_W-1:0] tdata,
  input  logic [pip_pkg::IN_TUSER_W-1:0] tuser,
  input  logic                          tlast,
  output logic                          push,
  output pip_pkg::entry_t               entry
);

  localparam int CW = pip_pkg::COORD_WIDTH;
  localparam int DW = pip_pkg::DIFF_W;

  logic signed [CW-1:0] query_x_r, query_y_r;
  logic signed [CW-1:0] first_x_r, first_y_r;
  logic signed [CW-1:0] prev_x_r, prev_y_r;
  logic                 ring_started_r;
  logic [pip_pkg::CNT_W-1:0] ext_cnt_r, ext_cnt_nxt;

  logic signed [CW-1:0] cur_x, cur_y, first_x, first_y;
  logic [1:0]           action;
  logic                 ring_last, is_vertex, is_query, hole, close;

  function automatic pip_pkg::edge_t make_edge(
    input logic signed [CW-1:0] ix, input logic signed [CW-1:0] iy,
    input logic signed [CW-1:0] jx, input logic signed [CW-1:0] jy,
    input logic signed [CW-1:0] qx, input logic signed [CW-1:0] qy);
    pip_pkg::edge_t e;
    e.hit    = (iy > qy) != (jy > qy);
    e.dy     = DW'(jy) - DW'(iy);
    e.dy_neg = e.dy[DW-1];
    e.ax     = DW'(qx) - DW'(ix);
    e.dx     = DW'(jx) - DW'(ix);
    e.by     = DW'(qy) - DW'(iy);
    return e;
  endfunction

  assign cur_x     = tdata[CW-1:0];
  assign cur_y     = tdata[2*CW-1:CW];
  assign action    = tuser[1:0];
  assign ring_last = tuser[2];
  assign is_query  = (action == pip_pkg::ACT_QUERY);
  assign is_vertex = action inside {pip_pkg::ACT_EXTERIOR, pip_pkg::ACT_HOLE};
  assign hole      = (action == pip_pkg::ACT_HOLE);
  assign close     = ring_last | tlast;

  // A ring that starts on this word closes back to this very vertex.
  assign first_x = ring_started_r ? first_x_r : cur_x;
  assign first_y = ring_started_r ? first_y_r : cur_y;

  always_comb begin
    ext_cnt_nxt = ext_cnt_r;
    if (!hole && (ext_cnt_r < pip_pkg::CNT_W'(pip_pkg::MIN_EXTERIOR))) begin
      ext_cnt_nxt = ext_cnt_r + 1'b1;
    end
  end

  always_comb begin
    entry        = '0;
    entry.op     = is_query ? pip_pkg::OP_CLEAR : pip_pkg::OP_VERTEX;
    entry.hole   = hole;
    entry.close  = close;
    entry.emit   = tlast & is_vertex;
    entry.enough = (ext_cnt_nxt == pip_pkg::CNT_W'(pip_pkg::MIN_EXTERIOR));
    entry.e0     = make_edge(cur_x, cur_y, prev_x_r, prev_y_r, query_x_r, query_y_r);
    entry.e0.hit = entry.e0.hit & ring_started_r;
    entry.e1     = make_edge(first_x, first_y, cur_x, cur_y, query_x_r, query_y_r);
    entry.e1.hit = entry.e1.hit & close;
  end

  // The unused selector code is dropped here and never reaches the queue.
  assign push = accept & (is_query | is_vertex);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r      <= '0;
      query_y_r      <= '0;
      first_x_r      <= '0;
      first_y_r      <= '0;
      prev_x_r       <= '0;
      prev_y_r       <= '0;
      ring_started_r <= 1'b0;
      ext_cnt_r      <= '0;
    end else if (accept) begin
      case (action)
        pip_pkg::ACT_QUERY: begin
          query_x_r      <= cur_x;
          query_y_r      <= cur_y;
          ring_started_r <= 1'b0;
          ext_cnt_r      <= '0;
        end
        pip_pkg::ACT_EXTERIOR, pip_pkg::ACT_HOLE: begin
          ext_cnt_r      <= ext_cnt_nxt;
          first_x_r      <= first_x;
          first_y_r      <= first_y;
          prev_x_r       <= cur_x;
          prev_y_r       <= cur_y;
          ring_started_r <= !close;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/pip_queue.sv
// ----------------------------------------------------------------------------
// pip_queue : short first-in first-out queue between front and back end
// Register-based, depth from the package; full and empty come straight from
// a registered occupancy count.
// ----------------------------------------------------------------------------
module pip_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pip_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output pip_pkg::entry_t pop_data
);

  pip_pkg::entry_t              mem_r [pip_pkg::QDEPTH];
  logic [pip_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [pip_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                         do_push, do_pop;

  assign full      = (count_r == pip_pkg::QCNT_W'(pip_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push & !full;
  assign do_pop    = pop & not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == pip_pkg::QPTR_W'(pip_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == pip_pkg::QPTR_W'(pip_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Occupancy never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pip_pkg::QCNT_W'(pip_pkg::QDEPTH))
    else $error("queue occupancy beyond depth");

  // Without a pop, a full queue must stay full.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full)
    else $error("queue lost its full state without a pop");

endmodule

### rtl/pip_back.sv
// ----------------------------------------------------------------------------
// pip_back : edge evaluation, ring parity and result output
// Stage one forms the exact products of both edge tests; stage two
// compares them, updates exterior and hole parity and loads the output
// register when the word ends the polygon.
// ----------------------------------------------------------------------------
module pip_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_not_empty,
  input  pip_pkg::entry_t                q_data,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pip_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int PW = pip_pkg::PROD_W;

  typedef struct packed {
    pip_pkg::op_t          op;
    logic                  hole;
    logic                  close;
    logic                  emit;
    logic                  enough;
    logic                  hit0;
    logic                  neg0;
    logic                  hit1;
    logic                  neg1;
    logic signed [PW-1:0]  pa0;
    logic signed [PW-1:0]  pb0;
    logic signed [PW-1:0]  pa1;
    logic signed [PW-1:0]  pb1;
  } mstage_t;

  mstage_t m_r, m_nxt;
  logic    m_valid_r;
  logic    m_advance;
  logic    ext_par_r, hole_par_r, in_hole_r;
  logic    ext_par_nxt, hole_par_nxt, in_hole_nxt;
  logic    c0, c1, flip, hp;
  logic    out_valid_r, out_load;
  logic [pip_pkg::OUT_TDATA_W-1:0] out_data_r;

  // Product stage: two products per edge.
  always_comb begin
    m_nxt        = '0;
    m_nxt.op     = q_data.op;
    m_nxt.hole   = q_data.hole;
    m_nxt.close  = q_data.close;
    m_nxt.emit   = q_data.emit;
    m_nxt.enough = q_data.enough;
    m_nxt.hit0   = q_data.e0.hit;
    m_nxt.neg0   = q_data.e0.dy_neg;
    m_nxt.hit1   = q_data.e1.hit;
    m_nxt.neg1   = q_data.e1.dy_neg;
    m_nxt.pa0    = q_data.e0.ax * q_data.e0.dy;
    m_nxt.pb0    = q_data.e0.dx * q_data.e0.by;
    m_nxt.pa1    = q_data.e1.ax * q_data.e1.dy;
    m_nxt.pb1    = q_data.e1.dx * q_data.e1.by;
  end

  assign m_advance = m_valid_r & (!m_r.emit | !out_valid_r | out_tready);
  assign q_pop     = q_not_empty & (!m_valid_r | m_advance);
  assign out_load  = m_advance & m_r.emit;

  // Crossing to the right; the relation flips when dy is negative.
  assign c0   = m_r.hit0 & (m_r.neg0 ? (m_r.pb0 < m_r.pa0) : (m_r.pa0 < m_r.pb0));
  assign c1   = m_r.hit1 & (m_r.neg1 ? (m_r.pb1 < m_r.pa1) : (m_r.pa1 < m_r.pb1));
  assign flip = c0 ^ c1;

  always_comb begin
    ext_par_nxt  = ext_par_r;
    hole_par_nxt = hole_par_r;
    in_hole_nxt  = in_hole_r;
    hp           = hole_par_r ^ (m_r.hole & flip);
    if (m_advance) begin
      if (m_r.op == pip_pkg::OP_CLEAR) begin
        ext_par_nxt  = 1'b0;
        hole_par_nxt = 1'b0;
        in_hole_nxt  = 1'b0;
      end else begin
        ext_par_nxt  = ext_par_r ^ (!m_r.hole & flip);
        hole_par_nxt = hp;
        if (m_r.close) begin
          in_hole_nxt  = in_hole_r | hp;
          hole_par_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      ext_par_r   <= 1'b0;
      hole_par_r  <= 1'b0;
      in_hole_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        m_valid_r <= 1'b1;
      end else if (m_advance) begin
        m_valid_r <= 1'b0;
      end
      ext_par_r   <= ext_par_nxt;
      hole_par_r  <= hole_par_nxt;
      in_hole_r   <= in_hole_nxt;
      out_valid_r <= out_load | (out_valid_r & !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_r <= m_nxt;
    end
    if (out_load) begin
      out_data_r <= {(pip_pkg::OUT_TDATA_W - 2)'(0), !m_r.enough,
                     m_r.enough & ext_par_nxt & !in_hole_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A query word leaves all parity state cleared.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (m_advance && m_r.op == pip_pkg::OP_CLEAR) |=> (!ext_par_r && !hole_par_r && !in_hole_r))
    else $error("parity state not cleared by query word");

  // Closing a ring always leaves the hole parity at zero.
  a_ring_close: assert property (@(posedge clk) disable iff (!rst_n)
    (m_advance && m_r.op == pip_pkg::OP_VERTEX && m_r.close) |=> !hole_par_r)
    else $error("hole parity survived a ring end");

  // A result appears only from a polygon-ending word.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(m_advance && m_r.emit))
    else $error("result raised without a polygon end");

  // The product stage never advances a word while the result register blocks it.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && m_valid_r && m_r.emit) |-> !m_advance)
    else $error("result overwritten while stalled");

endmodule
